/* hdl/scalar_guest_core_execute_macros.svh */
// assertion shorthands for the guest core checker
`ifndef SCALAR_GUEST_CORE_EXECUTE_MACROS_SVH
`define SCALAR_GUEST_CORE_EXECUTE_MACROS_SVH

// same-cycle implication, off while in reset
`define SGCE_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("guest core check failed");

// next-cycle implication, off while in reset
`define SGCE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("guest core check failed");

// next-cycle implication, also checked across reset
`define SGCE_ASSERT_NEXT_NR(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("guest core check failed");

`endif

/* hdl/sgce_pkg.sv */
`default_nettype none

package sgce_pkg;

  // sizes
  localparam int XLEN      = 64;
  localparam int MEM_BYTES = 65536;
  localparam int NUM_REGS  = 16;
  localparam int MEM_AW    = $clog2(MEM_BYTES);
  localparam int REG_AW    = $clog2(NUM_REGS);
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 2;
  // bounds arithmetic width: holds mem_limit and MEM_BYTES
  localparam int LIM_W     = (MEM_AW + 1 > CFG_W) ? MEM_AW + 1 : CFG_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONSOLE_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_PC     = 2'd2;

  // configuration reset values
  localparam logic [16:0] MEM_LIMIT_RST    = 17'd65536;
  localparam logic [15:0] CONSOLE_BASE_RST = 16'd65280;
  localparam logic [15:0] ENTRY_PC_RST     = 16'd0;

  // instruction modes
  localparam logic [2:0] MODE_MOV     = 3'd0;
  localparam logic [2:0] MODE_LEA     = 3'd1;
  localparam logic [2:0] MODE_SUB     = 3'd2;
  localparam logic [2:0] MODE_JZ      = 3'd3;
  localparam logic [2:0] MODE_HALT    = 3'd4;
  localparam logic [2:0] MODE_PRELOAD = 3'd5;

  // mov forms (also sub operand select: immediate form)
  localparam logic [2:0] FORM_IMM   = 3'd0;
  localparam logic [2:0] FORM_REG   = 3'd1;
  localparam logic [2:0] FORM_LOAD  = 3'd2;
  localparam logic [2:0] FORM_STORE = 3'd3;

  // result status codes
  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_HALTED  = 3'd1;
  localparam logic [2:0] ST_FAULT   = 3'd2;
  localparam logic [2:0] ST_ILLEGAL = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;

  localparam logic [XLEN-1:0] PC_STEP   = 64'd16;
  localparam logic [16:0]     CHAR_OFS  = 17'd8;

  typedef struct packed {
    logic [2:0]      mode;
    logic [3:0]      dest_reg;
    logic [3:0]      src_reg;
    logic [7:0]      aux_bits;
    logic [XLEN-1:0] immediate;
  } item_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [XLEN-1:0] pc_out;
    logic            console_valid;
    logic            console_kind;
    logic [XLEN-1:0] console_value;
  } result_t;

  // register file request from the sequencer
  typedef struct packed {
    logic              we;
    logic [REG_AW-1:0] waddr;
    logic [XLEN-1:0]   wdata;
    logic              re;
    logic [REG_AW-1:0] raddr;
  } rf_req_t;

  // index of the last byte of an access: 1, 2, 4 or 8 bytes
  function automatic logic [2:0] byte_last(input logic [1:0] sel);
    logic [2:0] last;
    case (sel)
      2'd0:    last = 3'd0;
      2'd1:    last = 3'd1;
      2'd2:    last = 3'd3;
      default: last = 3'd7;
    endcase
    return last;
  endfunction

endpackage

`default_nettype wire

/* hdl/sgce_ram.sv */
`default_nettype none

module sgce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hdl/sgce_alu.sv */
`default_nettype none

module sgce_alu (
  input  logic [sgce_pkg::XLEN-1:0] a,
  input  logic [sgce_pkg::XLEN-1:0] b,
  input  logic                      sub,
  output logic [sgce_pkg::XLEN-1:0] y
);

  import sgce_pkg::*;

  // shared 64-bit adder: address, lea sum and sub difference
  assign y = sub ? (a - b) : (a + b);

endmodule

`default_nettype wire

/* hdl/sgce_regfile.sv */
`default_nettype none

module sgce_regfile (
  input  logic                      clk,
  input  logic                      rst,
  input  sgce_pkg::rf_req_t         req,
  output logic [sgce_pkg::XLEN-1:0] rdata
);

  import sgce_pkg::*;

  logic [NUM_REGS-1:0] vld;
  logic                rvld;
  logic                wr_en;
  logic [XLEN-1:0]     ram_q;

  // r0 is never written, so it always reads zero
  assign wr_en = req.we && (req.waddr != '0);

  sgce_ram #(
    .WIDTH(XLEN),
    .DEPTH(NUM_REGS)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(req.waddr),
    .wdata(req.wdata),
    .re   (req.re),
    .raddr(req.raddr),
    .rdata(ram_q)
  );

  // written-since-reset bits, sampled alongside the read
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      rvld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[req.waddr] <= 1'b1;
      end
      if (req.re) begin
        rvld <= vld[req.raddr];
      end
    end
  end

  assign rdata = rvld ? ram_q : '0;

endmodule

`default_nettype wire

/* hdl/scalar_guest_core_execute.sv */
`default_nettype none
// jz, halt, illegal, preload, immediate and no-op moves and after-stop items go from decode
// to the result; other register ops read the register file first; faults and console stores
// end at the bounds check; loads and stores (1, 2, 4 or 8 bytes) then use the byte-wide port
// throughput: one item at a time, next beat taken after the result registers; a stalled
// earlier result holds the finish until the stall drops
// reset: synchronous; memory zeroed a byte a cycle over all 65536 bytes, with items stalled

module scalar_guest_core_execute (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  sgce_pkg::item_t                item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output sgce_pkg::result_t              result,
  input  logic                           cfg_we,
  input  logic [sgce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sgce_pkg::CFG_W-1:0]     cfg_data
);

  import sgce_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_RD1,
    S_RD2,
    S_RD3,
    S_ALU,
    S_CHECK,
    S_LOAD,
    S_LOAD_END,
    S_STORE,
    S_DONE
  } state_t;

  state_t            state;
  logic [MEM_AW-1:0] clr_addr;
  item_t             cur;
  logic [XLEN-1:0]   opa;
  logic [XLEN-1:0]   opb;
  logic [XLEN-1:0]   alu_q;
  logic [MEM_AW-1:0] maddr;
  logic [2:0]        cnt;
  logic [2:0]        pidx;
  logic              pend;
  logic [XLEN-1:0]   ldval;
  logic [2:0]        fin_status;
  logic [XLEN-1:0]   fin_pc;
  logic              fin_cv;
  logic              fin_ck;
  logic [XLEN-1:0]   fin_cval;
  logic [XLEN-1:0]   prog_counter;
  logic              zero_flag;
  logic              stopped;
  logic [16:0]       mem_limit;
  logic [15:0]       console_base;

  logic [2:0]        form;
  logic [2:0]        last;
  logic [XLEN-1:0]   pc_inc;
  logic              need_b;
  logic [XLEN-1:0]   alu_a;
  logic [XLEN-1:0]   alu_b;
  logic              alu_sub;
  logic [XLEN-1:0]   alu_y;
  logic [LIM_W-1:0]  lim_cfg;
  logic [LIM_W-1:0]  lim;
  logic [LIM_W:0]    ea_end;
  logic              ea_ok;
  logic              hit_word;
  logic              hit_char;
  logic              imm_in_mem;
  logic [XLEN-1:0]   ld_merge;
  logic [XLEN-1:0]   rf_rdata;
  rf_req_t           rf_req;
  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_re;
  logic [7:0]        mem_rdata;

  assign item_stall = (state != S_IDLE);

  // decode helpers
  assign form       = cur.aux_bits[2:0];
  assign last       = byte_last(cur.aux_bits[5:4]);
  assign pc_inc     = prog_counter + PC_STEP;
  assign need_b     = ((cur.mode == MODE_MOV) && (form == FORM_STORE)) ||
                      ((cur.mode == MODE_SUB) && (form != FORM_IMM));
  assign imm_in_mem = (cur.immediate < XLEN'(MEM_BYTES));

  // shared adder operands
  assign alu_a   = ((cur.mode == MODE_MOV) && (form == FORM_STORE)) ? opb : opa;
  assign alu_b   = ((cur.mode == MODE_SUB) && (form != FORM_IMM)) ? opb : cur.immediate;
  assign alu_sub = (cur.mode == MODE_SUB);

  sgce_alu u_alu (
    .a  (alu_a),
    .b  (alu_b),
    .sub(alu_sub),
    .y  (alu_y)
  );

  // bounds check without address wrap
  assign lim_cfg  = LIM_W'(mem_limit);
  assign lim      = (lim_cfg > LIM_W'(MEM_BYTES)) ? LIM_W'(MEM_BYTES) : lim_cfg;
  assign ea_end   = {1'b0, alu_q[LIM_W-1:0]} + (LIM_W+1)'(last) + (LIM_W+1)'(1);
  assign ea_ok    = (alu_q[XLEN-1:LIM_W] == '0) && (ea_end <= {1'b0, lim});
  assign hit_word = (alu_q == XLEN'(console_base));
  assign hit_char = (alu_q == XLEN'({1'b0, console_base} + CHAR_OFS));

  // fold the byte arriving from memory into the load value
  always_comb begin
    ld_merge = ldval;
    ld_merge[{pidx, 3'b000} +: 8] = mem_rdata;
  end

  // register file requests
  always_comb begin
    rf_req       = '0;
    rf_req.waddr = cur.dest_reg;
    unique case (state)
      S_DECODE: begin
        if ((cur.mode == MODE_MOV) && (form == FORM_IMM) && !stopped) begin
          rf_req.we    = 1'b1;
          rf_req.wdata = cur.immediate;
        end
      end
      S_RD1: begin
        rf_req.re    = 1'b1;
        rf_req.raddr = (cur.mode == MODE_SUB) ? cur.dest_reg : cur.src_reg;
      end
      S_RD2: begin
        if (need_b) begin
          rf_req.re    = 1'b1;
          rf_req.raddr = (cur.mode == MODE_SUB) ? cur.src_reg : cur.dest_reg;
        end else if ((cur.mode == MODE_MOV) && (form == FORM_REG)) begin
          rf_req.we    = 1'b1;
          rf_req.wdata = rf_rdata;
        end
      end
      S_ALU: begin
        if ((cur.mode == MODE_LEA) || (cur.mode == MODE_SUB)) begin
          rf_req.we    = 1'b1;
          rf_req.wdata = alu_y;
        end
      end
      S_LOAD_END: begin
        rf_req.we    = 1'b1;
        rf_req.wdata = ld_merge;
      end
      default: begin
      end
    endcase
  end

  sgce_regfile u_regfile (
    .clk  (clk),
    .rst  (rst),
    .req  (rf_req),
    .rdata(rf_rdata)
  );

  // guest memory port: clearing pass, preload, store and load bytes
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = maddr;
    mem_wdata = opa[{cnt, 3'b000} +: 8];
    mem_re    = 1'b0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      S_DECODE: begin
        if ((cur.mode == MODE_PRELOAD) && imm_in_mem) begin
          mem_we    = 1'b1;
          mem_waddr = cur.immediate[MEM_AW-1:0];
          mem_wdata = cur.aux_bits;
        end
      end
      S_STORE: mem_we = 1'b1;
      S_LOAD:  mem_re = 1'b1;
      default: begin
      end
    endcase
  end

  sgce_ram #(
    .WIDTH(8),
    .DEPTH(MEM_BYTES)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(maddr),
    .rdata(mem_rdata)
  );

  // sequencer, architectural state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
      zero_flag    <= 1'b0;
      stopped      <= 1'b0;
      prog_counter <= XLEN'(ENTRY_PC_RST);
      mem_limit    <= MEM_LIMIT_RST;
      console_base <= CONSOLE_BASE_RST;
    end else begin
      // a taken result beat drops valid unless a new one is loaded below
      if (result_valid && !result_stall && (state != S_DONE)) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + MEM_AW'(1);
          if (clr_addr == MEM_AW'(MEM_BYTES - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (item_valid) begin
            cur   <= item;
            state <= S_DECODE;
          end
        end

        S_DECODE: begin
          fin_status <= ST_DONE;
          fin_pc     <= pc_inc;
          fin_cv     <= 1'b0;
          fin_ck     <= 1'b0;
          fin_cval   <= '0;
          if (cur.mode == MODE_PRELOAD) begin
            fin_pc <= prog_counter;
            state  <= S_DONE;
          end else if (stopped) begin
            fin_status <= ST_IGNORED;
            fin_pc     <= prog_counter;
            state      <= S_DONE;
          end else begin
            unique case (cur.mode) inside
              MODE_MOV: begin
                unique case (form) inside
                  FORM_REG, FORM_LOAD, FORM_STORE: state <= S_RD1;
                  default:                         state <= S_DONE;
                endcase
              end
              MODE_LEA, MODE_SUB: state <= S_RD1;
              MODE_JZ: begin
                fin_pc <= zero_flag ? cur.immediate : pc_inc;
                state  <= S_DONE;
              end
              MODE_HALT: begin
                fin_status <= ST_HALTED;
                fin_pc     <= prog_counter;
                stopped    <= 1'b1;
                state      <= S_DONE;
              end
              default: begin
                fin_status <= ST_ILLEGAL;
                fin_pc     <= prog_counter;
                stopped    <= 1'b1;
                state      <= S_DONE;
              end
            endcase
          end
        end

        S_RD1: state <= S_RD2;

        S_RD2: begin
          opa <= rf_rdata;
          if (need_b) begin
            state <= S_RD3;
          end else if ((cur.mode == MODE_MOV) && (form == FORM_REG)) begin
            state <= S_DONE;
          end else begin
            state <= S_ALU;
          end
        end

        S_RD3: begin
          opb   <= rf_rdata;
          state <= S_ALU;
        end

        S_ALU: begin
          if (cur.mode == MODE_MOV) begin
            alu_q <= alu_y;
            state <= S_CHECK;
          end else begin
            if (cur.mode == MODE_SUB) begin
              zero_flag <= (alu_y == '0);
            end
            state <= S_DONE;
          end
        end

        S_CHECK: begin
          cnt   <= '0;
          pend  <= 1'b0;
          ldval <= '0;
          maddr <= alu_q[MEM_AW-1:0];
          if (!ea_ok) begin
            fin_status <= ST_FAULT;
            fin_pc     <= prog_counter;
            stopped    <= 1'b1;
            state      <= S_DONE;
          end else if (form == FORM_LOAD) begin
            state <= S_LOAD;
          end else if (hit_word) begin
            fin_cv   <= 1'b1;
            fin_cval <= opa;
            state    <= S_DONE;
          end else if (hit_char) begin
            fin_cv   <= 1'b1;
            fin_ck   <= 1'b1;
            fin_cval <= {{(XLEN-8){1'b0}}, opa[7:0]};
            state    <= S_DONE;
          end else begin
            state <= S_STORE;
          end
        end

        // one byte read issued per cycle, its data folded in on the cycle after
        S_LOAD: begin
          pend  <= 1'b1;
          pidx  <= cnt;
          maddr <= maddr + MEM_AW'(1);
          cnt   <= cnt + 3'd1;
          if (pend) begin
            ldval <= ld_merge;
          end
          if (cnt == last) begin
            state <= S_LOAD_END;
          end
        end

        S_LOAD_END: state <= S_DONE;

        S_STORE: begin
          maddr <= maddr + MEM_AW'(1);
          cnt   <= cnt + 3'd1;
          if (cnt == last) begin
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            result       <= '{status:        fin_status,
                              pc_out:        fin_pc,
                              console_valid: fin_cv,
                              console_kind:  fin_ck,
                              console_value: fin_cval};
            prog_counter <= fin_pc;
            state        <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase

      // configuration writes, expected only while idle
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MEM_LIMIT:    mem_limit    <= cfg_data;
          CFG_CONSOLE_BASE: console_base <= cfg_data[15:0];
          CFG_ENTRY_PC:     prog_counter <= XLEN'(cfg_data[15:0]);
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/sgce_checker.sv */
`default_nettype none
`include "scalar_guest_core_execute_macros.svh"

module sgce_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input logic              result_valid,
  input logic              result_stall,
  input sgce_pkg::result_t result
);

  import sgce_pkg::*;

  // the core is busy in the cycle after taking a beat
  `SGCE_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall)

  // memory clearing follows reset, so no beat is taken right after it
  `SGCE_ASSERT_NEXT_NR(a_stall_after_reset, rst, item_stall)

  // console fields are zero unless a console event is reported
  `SGCE_ASSERT_IMPLY(a_quiet_console, result_valid && !result.console_valid,
                     !result.console_kind && (result.console_value == '0))

  // console events only come from completed stores
  `SGCE_ASSERT_IMPLY(a_console_done, result_valid && result.console_valid,
                     result.status == ST_DONE)

  // a stalled result beat stays put
  `SGCE_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
                    result_valid && $stable(result))

endmodule

bind scalar_guest_core_execute sgce_checker u_sgce_checker (.*);

`default_nettype wire

/* test/tb_scalar_guest_core_execute.sv */
`default_nettype none

module tb_scalar_guest_core_execute;
  import sgce_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN_CYCLES = 20;

  // modes with no instruction behind them
  localparam logic [2:0] MODE_BAD_A = 3'd6;
  localparam logic [2:0] MODE_BAD_B = 3'd7;
  // first of the mov forms that do nothing
  localparam logic [2:0] FORM_NOP = 3'd4;
  // access width selects
  localparam logic [1:0] SEL_B1 = 2'd0;
  localparam logic [1:0] SEL_B8 = 2'd3;

  // tracks the architectural state and the results still owed by the core
  class guest_exec_tracker;
    logic [XLEN-1:0] regs [NUM_REGS];
    logic [7:0]      mem [MEM_BYTES];
    logic            zflag;
    logic [XLEN-1:0] pc;
    logic            stopped;
    logic [16:0]     mem_limit;
    logic [15:0]     con_base;
    logic [15:0]     entry_pc;
    result_t         pending_results[$];
    int              errors;
    int              n_items;
    int              n_mem;
    int              n_console;
    int              n_jumps;
    logic [2:0]      stop_status;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (mem[i]) mem[i] = '0;
      zflag = 1'b0;
      stopped = 1'b0;
      mem_limit = MEM_LIMIT_RST;
      con_base = CONSOLE_BASE_RST;
      entry_pc = ENTRY_PC_RST;
      pc = XLEN'(ENTRY_PC_RST);
      errors = 0;
      n_items = 0;
      n_mem = 0;
      n_console = 0;
      n_jumps = 0;
      stop_status = ST_DONE;
    endfunction

    function logic [XLEN-1:0] rd(logic [3:0] idx);
      return (idx == 0) ? '0 : regs[idx];
    endfunction

    function void wr(logic [3:0] idx, logic [XLEN-1:0] val);
      if (idx != 0) regs[idx] = val;
    endfunction

    // usable memory size, clamped to the physical array
    function logic [XLEN-1:0] bound();
      return (64'(mem_limit) > 64'(MEM_BYTES)) ? 64'(MEM_BYTES) : 64'(mem_limit);
    endfunction

    // bounds check without address wrap
    function bit fits(logic [XLEN-1:0] ea, logic [1:0] sel);
      logic [XLEN-1:0] w;
      logic [XLEN-1:0] lim;
      w = 64'd1 << sel;
      lim = bound();
      if (w > lim) return 1'b0;
      return ea <= lim - w;
    endfunction

    // would this instruction stop the core
    function bit stops(item_t it);
      if (it.mode == MODE_PRELOAD || stopped) return 1'b0;
      case (it.mode)
        MODE_MOV: begin
          if (it.aux_bits[2:0] == FORM_LOAD)
            return !fits(rd(it.src_reg) + it.immediate, it.aux_bits[5:4]);
          if (it.aux_bits[2:0] == FORM_STORE)
            return !fits(rd(it.dest_reg) + it.immediate, it.aux_bits[5:4]);
          return 1'b0;
        end
        MODE_LEA, MODE_SUB, MODE_JZ: return 1'b0;
        default: return 1'b1;
      endcase
    endfunction

    function void set_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_MEM_LIMIT: mem_limit = val;
        CFG_CONSOLE_BASE: con_base = val[15:0];
        CFG_ENTRY_PC: begin
          entry_pc = val[15:0];
          pc = XLEN'(val[15:0]);
        end
        default: ;
      endcase
    endfunction

    // execute one accepted instruction and queue the result it owes
    function void accept_instr(item_t it);
      result_t         r;
      logic [XLEN-1:0] ea;
      logic [XLEN-1:0] v;
      logic [XLEN-1:0] w;
      logic [XLEN-1:0] diff;
      logic [XLEN-1:0] opnd;
      logic [2:0]      form;
      r = '0;
      r.status = ST_DONE;
      r.pc_out = pc;
      form = it.aux_bits[2:0];
      w = 64'd1 << it.aux_bits[5:4];
      n_items++;
      if (it.mode == MODE_PRELOAD) begin
        if (it.immediate < 64'(MEM_BYTES)) mem[it.immediate[MEM_AW-1:0]] = it.aux_bits;
      end else if (stopped) begin
        r.status = ST_IGNORED;
      end else begin
        case (it.mode)
          MODE_MOV: begin
            r.pc_out = pc + PC_STEP;
            case (form)
              FORM_IMM: wr(it.dest_reg, it.immediate);
              FORM_REG: wr(it.dest_reg, rd(it.src_reg));
              FORM_LOAD: begin
                ea = rd(it.src_reg) + it.immediate;
                if (!fits(ea, it.aux_bits[5:4])) begin
                  r.status = ST_FAULT;
                end else begin
                  v = '0;
                  for (int k = 0; k < w; k++)
                    v |= 64'(mem[int'(ea[MEM_AW-1:0]) + k]) << (8 * k);
                  wr(it.dest_reg, v);
                  n_mem++;
                end
              end
              FORM_STORE: begin
                ea = rd(it.dest_reg) + it.immediate;
                v = rd(it.src_reg);
                if (!fits(ea, it.aux_bits[5:4])) begin
                  r.status = ST_FAULT;
                end else if (ea == 64'(con_base)) begin
                  r.console_valid = 1'b1;
                  r.console_value = v;
                end else if (ea == 64'(con_base) + 64'(CHAR_OFS)) begin
                  r.console_valid = 1'b1;
                  r.console_kind = 1'b1;
                  r.console_value = {56'd0, v[7:0]};
                end else begin
                  for (int k = 0; k < w; k++)
                    mem[int'(ea[MEM_AW-1:0]) + k] = v[8*k +: 8];
                  n_mem++;
                end
              end
              default: ;
            endcase
            if (r.status == ST_FAULT) r.pc_out = pc;
          end
          MODE_LEA: begin
            wr(it.dest_reg, rd(it.src_reg) + it.immediate);
            r.pc_out = pc + PC_STEP;
          end
          MODE_SUB: begin
            opnd = (form == FORM_IMM) ? it.immediate : rd(it.src_reg);
            diff = rd(it.dest_reg) - opnd;
            wr(it.dest_reg, diff);
            zflag = (diff == 0);
            r.pc_out = pc + PC_STEP;
          end
          MODE_JZ: begin
            r.pc_out = zflag ? it.immediate : pc + PC_STEP;
            if (zflag) n_jumps++;
          end
          MODE_HALT: r.status = ST_HALTED;
          default: r.status = ST_ILLEGAL;
        endcase
        if (r.status != ST_DONE) begin
          stopped = 1'b1;
          stop_status = r.status;
        end
      end
      pc = r.pc_out;
      if (r.console_valid) n_console++;
      pending_results.push_back(r);
    endfunction

    // compare a result beat against the oldest owed result
    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result beat: status %0d pc %h console %b/%b %h",
                   got.status, got.pc_out, got.console_valid, got.console_kind,
                   got.console_value);
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status || got.pc_out !== want.pc_out ||
          got.console_valid !== want.console_valid ||
          got.console_kind !== want.console_kind ||
          got.console_value !== want.console_value) begin
        errors++;
        if (errors <= 10) begin
          $display("result mismatch: expected status %0d pc %h console %b/%b %h",
                   want.status, want.pc_out, want.console_valid, want.console_kind,
                   want.console_value);
          $display("                 actual   status %0d pc %h console %b/%b %h",
                   got.status, got.pc_out, got.console_valid, got.console_kind,
                   got.console_value);
        end
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 item_valid;
  logic                 item_stall;
  item_t                item;
  logic                 result_valid;
  logic                 result_stall;
  result_t              result;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  guest_exec_tracker tracker;
  bit                quiet;
  bit                hold_req;
  int                hold_left;
  int                burst_left;
  int                cycles;
  logic [15:0]       win_lo;

  scalar_guest_core_execute u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // clock
  always #10 clk = ~clk;

  // beat monitors on both channels
  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall) tracker.accept_instr(item);
    if (!rst && result_valid && !result_stall) tracker.check_result(result);
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: random stall bursts plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      result_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      result_stall <= 1'b1;
    end else if (!quiet && !rst && $urandom_range(0, 5) == 0) begin
      burst_left = $urandom_range(0, 3);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  function automatic item_t instr(logic [2:0] m, logic [3:0] d, logic [3:0] s,
                                  logic [7:0] a, logic [XLEN-1:0] imm);
    item_t it;
    it.mode = m;
    it.dest_reg = d;
    it.src_reg = s;
    it.aux_bits = a;
    it.immediate = imm;
    return it;
  endfunction

  // 64-bit values biased to the extremes
  function automatic logic [XLEN-1:0] rand_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return {1'b1, 63'd0};
      3: return 64'($urandom_range(0, 65535));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // random instruction; accesses mostly land in bounds near the current window
  function automatic item_t make_random(input bit may_stop);
    item_t           it;
    int              pick;
    int              hi;
    int              lo;
    int              top;
    logic [1:0]      sel;
    logic [XLEN-1:0] w;
    logic [XLEN-1:0] lim;
    logic [XLEN-1:0] ea;
    do begin
      pick = $urandom_range(0, 99);
      sel = 2'($urandom);
      it.mode = 3'($urandom);
      it.dest_reg = 4'($urandom);
      it.src_reg = 4'($urandom);
      it.aux_bits = 8'($urandom);
      it.immediate = rand_word();
      if (pick < 14) begin
        it.mode = MODE_MOV;
        it.aux_bits[2:0] = FORM_IMM;
      end else if (pick < 22) begin
        it.mode = MODE_MOV;
        it.aux_bits[2:0] = FORM_REG;
      end else if (pick < 50) begin
        it.mode = MODE_MOV;
        it.aux_bits[5:4] = sel;
        w = 64'd1 << sel;
        lim = tracker.bound();
        if (w > lim) begin
          it.aux_bits[2:0] = FORM_IMM;
        end else begin
          hi = int'(lim - w);
          lo = (int'(win_lo) > hi) ? 0 : int'(win_lo);
          top = (lo + 40 > hi) ? hi : lo + 40;
          ea = 64'($urandom_range(lo, top));
          if (pick >= 36) begin
            it.aux_bits[2:0] = FORM_STORE;
            if ($urandom_range(0, 3) == 0)
              ea = $urandom_range(0, 1) ? 64'(tracker.con_base)
                                        : 64'(tracker.con_base) + 64'(CHAR_OFS);
            it.immediate = ea - tracker.rd(it.dest_reg);
          end else begin
            it.aux_bits[2:0] = FORM_LOAD;
            it.immediate = ea - tracker.rd(it.src_reg);
          end
        end
      end else if (pick < 58) begin
        it.mode = MODE_LEA;
      end else if (pick < 70) begin
        it.mode = MODE_SUB;
        // often subtract the register from itself to raise the zero flag
        if ($urandom_range(0, 2) == 0) begin
          it.aux_bits[2:0] = FORM_IMM;
          it.immediate = tracker.rd(it.dest_reg);
        end else if ($urandom_range(0, 1) == 0) begin
          it.aux_bits[2:0] = FORM_IMM;
        end
      end else if (pick < 78) begin
        it.mode = MODE_JZ;
        if ($urandom_range(0, 1) == 0) it.immediate = 64'($urandom_range(0, 4095)) << 4;
      end else if (pick < 88) begin
        it.mode = MODE_PRELOAD;
        if ($urandom_range(0, 6) != 0)
          it.immediate = 64'(win_lo) + 64'($urandom_range(0, 48));
      end else if (pick < 93) begin
        it.mode = MODE_MOV;
        it.aux_bits[2] = FORM_NOP[2];
      end
    end while (!may_stop && tracker.stops(it));
    return it;
  endfunction

  // one instruction that stops the core: halt, illegal or a bounds fault
  function automatic item_t make_stopper();
    item_t           it;
    logic [XLEN-1:0] ea;
    logic [XLEN-1:0] w;
    it = instr(3'($urandom), 4'($urandom), 4'($urandom), 8'($urandom), rand_word());
    case ($urandom_range(0, 3))
      0: it.mode = MODE_HALT;
      1: it.mode = $urandom_range(0, 1) ? MODE_BAD_A : MODE_BAD_B;
      default: begin
        it.mode = MODE_MOV;
        it.aux_bits[2:0] = $urandom_range(0, 1) ? FORM_LOAD : FORM_STORE;
        if ($urandom_range(0, 1) == 0) begin
          // just past the end
          w = 64'd1 << it.aux_bits[5:4];
          ea = tracker.bound() - w + 64'd1;
        end else begin
          // top of the address space, where a wrapping sum would look small
          it.aux_bits[5:4] = SEL_B8;
          ea = '1 - 64'($urandom_range(0, 6));
        end
        if (it.aux_bits[2:0] == FORM_LOAD) it.immediate = ea - tracker.rd(it.src_reg);
        else it.immediate = ea - tracker.rd(it.dest_reg);
      end
    endcase
    return it;
  endfunction

  // offer one instruction beat, with an occasional idle burst ahead of it
  task automatic send_instr(input item_t it);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  task automatic run_random(input int n);
    repeat (n) send_instr(make_random(1'b0));
  endtask

  // stop offering and wait for every owed result
  task automatic drain();
    item_valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    tracker.set_config(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_phase(input logic [16:0] lim, input logic [15:0] cbase,
                           input logic [15:0] entry, input logic [15:0] win);
    drain();
    write_cfg(CFG_MEM_LIMIT, lim);
    write_cfg(CFG_CONSOLE_BASE, CFG_W'(cbase));
    write_cfg(CFG_ENTRY_PC, CFG_W'(entry));
    win_lo = win;
  endtask

  initial begin
    item_t directed[$];
    logic [16:0] rlim;
    clk = 1'b0;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    burst_left = 0;
    cycles = 0;
    win_lo = '0;
    tracker = new();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset values written back while memory clears
    write_cfg(CFG_MEM_LIMIT, MEM_LIMIT_RST);
    write_cfg(CFG_CONSOLE_BASE, CFG_W'(CONSOLE_BASE_RST));
    write_cfg(CFG_ENTRY_PC, CFG_W'(ENTRY_PC_RST));

    // directed: register moves, memory edges, console, arithmetic, branches
    directed.push_back(instr(MODE_MOV, 0, 5, 8'hC8, '1));
    directed.push_back(instr(MODE_MOV, 15, 0, 8'h00, '1));
    directed.push_back(instr(MODE_MOV, 1, 15, 8'h01, '0));
    directed.push_back(instr(MODE_MOV, 2, 0, 8'hF9, '1));
    directed.push_back(instr(MODE_PRELOAD, 0, 0, 8'hFF, 64'd0));
    directed.push_back(instr(MODE_PRELOAD, 15, 15, 8'h81, 64'd7));
    directed.push_back(instr(MODE_PRELOAD, 0, 0, 8'hA5, 64'd65535));
    directed.push_back(instr(MODE_PRELOAD, 0, 0, 8'h5A, 64'd65536));
    directed.push_back(instr(MODE_PRELOAD, 0, 0, 8'h3C, '1));
    directed.push_back(instr(MODE_MOV, 3, 0, 8'h32, 64'd0));
    directed.push_back(instr(MODE_MOV, 4, 0, 8'h02, 64'd65535));
    directed.push_back(instr(MODE_MOV, 6, 15, 8'h12, 64'd65535));
    directed.push_back(instr(MODE_MOV, 0, 15, 8'h23, 64'h100));
    directed.push_back(instr(MODE_MOV, 7, 0, 8'hE2, 64'h100));
    directed.push_back(instr(MODE_MOV, 0, 15, 8'h33, 64'hFF00));
    directed.push_back(instr(MODE_MOV, 0, 4, 8'h03, 64'hFF08));
    directed.push_back(instr(MODE_MOV, 1, 15, 8'h13, 64'h201));
    directed.push_back(instr(MODE_LEA, 5, 15, 8'h00, 64'd1));
    directed.push_back(instr(MODE_SUB, 5, 0, 8'h00, 64'd0));
    directed.push_back(instr(MODE_JZ, 0, 0, 8'h00, 64'hFFFF_FFFF_FFFF_FFF0));
    directed.push_back(instr(MODE_SUB, 1, 2, 8'hFF, '0));
    directed.push_back(instr(MODE_JZ, 15, 15, 8'hFF, '1));
    directed.push_back(instr(MODE_MOV, 9, 9, 8'h04, '1));
    directed.push_back(instr(MODE_MOV, 10, 11, 8'h7F, '0));
    foreach (directed[i]) send_instr(directed[i]);

    // small memory near its top edge, with a full pause halfway
    set_phase(17'd4096, 16'h0100, 16'h1230, 16'h0FC0);
    run_random(50);
    drain();
    run_random(50);

    // limit above the array, console at the last byte; long result hold-off
    set_phase(17'h1FFFF, 16'hFFFF, 16'hFFF0, 16'hFFC0);
    run_random(30);
    hold_req = 1'b1;
    run_random(70);

    // no usable memory at all
    set_phase(17'd0, 16'h0000, 16'hFFFF, 16'h0000);
    run_random(40);

    // sixteen bytes, both console windows inside them
    set_phase(17'd16, 16'h0000, 16'h0000, 16'h0000);
    run_random(100);

    // random setting
    rlim = 17'($urandom_range(16, 65536));
    set_phase(rlim, 16'($urandom), 16'($urandom) & 16'hFFF0,
              16'($urandom_range(0, int'(rlim) - 16)));
    run_random(100);

    // last part without idling, then stop the core and keep offering beats
    set_phase(MEM_LIMIT_RST, CONSOLE_BASE_RST, 16'($urandom) & 16'hFFF0, 16'hFF00);
    quiet = 1'b1;
    run_random(60);
    send_instr(make_stopper());
    repeat (20) send_instr(make_random(1'b1));

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("ran %0d instructions: %0d memory moves, %0d console events, %0d taken jumps",
             tracker.n_items, tracker.n_mem, tracker.n_console, tracker.n_jumps);
    $display("core stopped with status %0d; %0d bad result beats",
             tracker.stop_status, tracker.errors);
    if (tracker.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+hdl
hdl/sgce_pkg.sv
hdl/sgce_ram.sv
hdl/sgce_alu.sv
hdl/sgce_regfile.sv
hdl/scalar_guest_core_execute.sv
hdl/sgce_checker.sv
test/tb_scalar_guest_core_execute.sv
